[rtl/lbc_pkg.sv]
package lbc_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 160;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam int GEOM_LAT   = 4;

  localparam int DIV_NW = 40;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = 6;

  localparam logic [31:0] LUM_K_R = 32'((64'd19635 * 64'd65536 + 64'd30) / 64'd31);
  localparam logic [31:0] LUM_K_G = 32'((64'd38250 * 64'd65536 + 64'd62) / 64'd63);
  localparam logic [31:0] LUM_K_B = 32'((64'd7395 * 64'd65536 + 64'd30) / 64'd31);

  localparam logic [14:0] RECIP_100 = 15'd20972;
  localparam int          RECIP_SH  = 21;
  localparam logic [7:0]  RECIP_5   = 8'd205;

  localparam logic [15:0] PIX_LIGHT = 16'hFFFF;
  localparam logic [15:0] PIX_DARK  = 16'h0000;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_DARK_THR     = 3'd2,
    CFG_ROI_TOP      = 3'd3,
    CFG_ROI_BOTTOM   = 3'd4,
    CFG_ROI_WIDTH    = 3'd5,
    CFG_ROI_OFFSET   = 3'd6,
    CFG_ACTIVE_DARK  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_CHANNEL = 2'd1,
    KIND_LINE    = 2'd2
  } result_kind_e;

  typedef enum logic [3:0] {
    BK_PIX,
    BK_PCT_GO,
    BK_PCT_WAIT,
    BK_CEN_GO,
    BK_CEN_WAIT,
    BK_CH_OUT,
    BK_LN_MUL,
    BK_LN_GO,
    BK_LN_WAIT,
    BK_LN_OUT
  } back_state_e;

  typedef struct packed {
    logic [15:0] word;
    logic        dark;
    logic [6:0]  x;
    logic [7:0]  y;
    logic        end_frame;
  } pix_entry_t;

  typedef struct packed {
    logic                        ok;
    logic [7:0]                  w;
    logic [7:0]                  h;
    logic [7:0]                  y0;
    logic [7:0]                  y1;
    logic [7:0]                  x0;
    logic [7:0]                  x1;
    logic [7:0]                  cx0;
    logic [7:0]                  cx1;
    logic [8:0]                  cxsum;
    logic [7:0]                  span;
    logic [CHANNELS-1:0][10:0]   bnd;
    logic [6:0]                  adp;
  } geom_t;

  function automatic logic [7:0] lum_of(input logic [15:0] word);
    logic [15:0] rgb;
    logic [31:0] pr;
    logic [31:0] pg;
    logic [31:0] pb;
    logic [16:0] sum;
    rgb = {word[7:0], word[15:8]};
    pr  = 32'(rgb[15:11]) * LUM_K_R;
    pg  = 32'(rgb[10:5]) * LUM_K_G;
    pb  = 32'(rgb[4:0]) * LUM_K_B;
    sum = 17'(pr >> 16) + 17'(pg >> 16) + 17'(pb >> 16);
    return sum[15:8];
  endfunction

endpackage

[rtl/lbc_div.sv]
module lbc_div import lbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quo_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] den_q, den_d;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_q, quo_q[DIV_NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/lbc_fifo.sv]
module lbc_fifo import lbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pix_entry_t push_data_i,
  input  logic       pop_i,
  output pix_entry_t pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  pix_entry_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d;
  logic [FIFO_AW-1:0] rptr_q, rptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  assign full_o     = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/lbc_front.sv]
module lbc_front import lbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pixel_word_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output pix_entry_t  entry_o,
  output geom_t       geom_o
);

  logic [7:0] fw_q, fh_q, thr_q;
  logic [6:0] top_q, bot_q, wpct_q, off_q, adp_q;
  logic [2:0] settle_q, settle_d;

  logic [7:0]  g1_w_q, g1_h_q;
  logic [14:0] g1_py0_q, g1_py1_q, g1_prw_q, g1_pso_q;
  logic        g1_neg_q;

  logic [7:0]  g2_w_q, g2_h_q, g2_y0_q, g2_y1_q, g2_rw_q, g2_so_q;
  logic        g2_neg_q;

  logic [7:0]  g3_w_q, g3_h_q, g3_y0_q, g3_y1_q, g3_x0_q, g3_x1_q, g3_rw_q, g3_ex_q;
  logic        g3_ok_q;

  geom_t       geom_q, geom_d;

  logic [7:0]  w_cl, h_cl;
  logic [6:0]  wp_cl, off_mag;
  logic [7:0]  wr, half, xs;
  logic [8:0]  xs_pos;
  logic [15:0] ex_prod;

  logic [6:0]  x_q, x_d;
  logic [7:0]  y_q, y_d;
  logic [7:0]  cw, ch;
  logic        end_row, end_frame, accept;

  function automatic logic [7:0] div100(input logic [14:0] p);
    logic [29:0] prod;
    prod = 30'(p) * 30'(RECIP_100);
    return 8'(prod >> RECIP_SH);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= 8'd128;
      fh_q   <= 8'd160;
      thr_q  <= 8'd110;
      top_q  <= 7'd0;
      bot_q  <= 7'd8;
      wpct_q <= 7'd30;
      off_q  <= 7'h79;
      adp_q  <= 7'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  fw_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q   <= cfg_data_i;
        CFG_DARK_THR:     thr_q  <= cfg_data_i;
        CFG_ROI_TOP:      top_q  <= cfg_data_i[6:0];
        CFG_ROI_BOTTOM:   bot_q  <= cfg_data_i[6:0];
        CFG_ROI_WIDTH:    wpct_q <= cfg_data_i[6:0];
        CFG_ROI_OFFSET:   off_q  <= cfg_data_i[6:0];
        CFG_ACTIVE_DARK:  adp_q  <= cfg_data_i[6:0];
      endcase
    end
  end

  always_comb begin
    if (cfg_we_i) begin
      settle_d = 3'(GEOM_LAT);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 3'(GEOM_LAT);
    end else begin
      settle_q <= settle_d;
    end
  end

  assign w_cl    = (fw_q > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : fw_q;
  assign h_cl    = (fh_q > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : fh_q;
  assign wp_cl   = (wpct_q > 7'd100) ? 7'd100 : wpct_q;
  assign off_mag = off_q[6] ? (~off_q + 7'd1) : off_q;

  assign wr      = g2_w_q - g2_rw_q;
  assign half    = {1'b0, wr[7:1]};
  assign xs_pos  = 9'(half) + 9'(g2_so_q);
  assign ex_prod = 16'(g2_rw_q) * 16'(RECIP_5);

  always_comb begin
    if (g2_neg_q) begin
      xs = (half >= g2_so_q) ? half - g2_so_q : 8'd0;
    end else begin
      xs = (xs_pos > 9'(wr)) ? wr : xs_pos[7:0];
    end
  end

  always_comb begin
    geom_d.ok    = g3_ok_q;
    geom_d.w     = g3_w_q;
    geom_d.h     = g3_h_q;
    geom_d.y0    = g3_y0_q;
    geom_d.y1    = g3_y1_q;
    geom_d.x0    = g3_x0_q;
    geom_d.x1    = g3_x1_q;
    geom_d.cx0   = g3_x0_q + g3_ex_q;
    geom_d.cx1   = g3_x1_q - g3_ex_q;
    geom_d.cxsum = 9'(g3_x0_q) + 9'(g3_x1_q);
    geom_d.span  = g3_rw_q - {g3_ex_q[6:0], 1'b0};
    geom_d.adp   = adp_q;
    for (int j = 0; j < CHANNELS; j++) begin
      geom_d.bnd[j] = 11'(g3_rw_q) * 11'(j);
    end
  end

  always_ff @(posedge clk_i) begin
    g1_w_q   <= w_cl;
    g1_h_q   <= h_cl;
    g1_py0_q <= 15'(h_cl) * 15'(top_q);
    g1_py1_q <= 15'(h_cl) * 15'(bot_q);
    g1_prw_q <= 15'(w_cl) * 15'(wp_cl);
    g1_pso_q <= 15'(w_cl) * 15'(off_mag);
    g1_neg_q <= off_q[6];

    g2_w_q   <= g1_w_q;
    g2_h_q   <= g1_h_q;
    g2_y0_q  <= div100(g1_py0_q);
    g2_y1_q  <= div100(g1_py1_q);
    g2_rw_q  <= div100(g1_prw_q);
    g2_so_q  <= div100(g1_pso_q);
    g2_neg_q <= g1_neg_q;

    g3_w_q   <= g2_w_q;
    g3_h_q   <= g2_h_q;
    g3_y0_q  <= g2_y0_q;
    g3_y1_q  <= g2_y1_q;
    g3_rw_q  <= g2_rw_q;
    g3_x0_q  <= xs;
    g3_x1_q  <= xs + g2_rw_q;
    g3_ex_q  <= ex_prod[15:8] >> 2;
    g3_ok_q  <= !(g2_w_q < 8'(CHANNELS) || g2_h_q == '0 ||
                  g2_y1_q <= g2_y0_q || g2_rw_q == '0);

    geom_q   <= geom_d;
  end

  assign cw        = (geom_q.w == '0) ? 8'd1 : geom_q.w;
  assign ch        = (geom_q.h == '0) ? 8'd1 : geom_q.h;
  assign end_row   = (8'(x_q) + 8'd1) >= cw;
  assign end_frame = end_row && ((9'(y_q) + 9'd1) >= 9'(ch));

  assign in_stall_o = fifo_full_i || (settle_q != '0);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (accept) begin
      if (end_row) begin
        x_d = '0;
        y_d = end_frame ? 8'd0 : y_q + 8'd1;
      end else begin
        x_d = x_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign push_o            = accept;
  assign entry_o.word      = pixel_word_i;
  assign entry_o.dark      = lum_of(pixel_word_i) <= thr_q;
  assign entry_o.x         = x_q;
  assign entry_o.y         = y_q;
  assign entry_o.end_frame = end_frame;
  assign geom_o            = geom_q;

endmodule

[rtl/lbc_back.sv]
module lbc_back import lbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  geom_t              geom_i,
  input  pix_entry_t         entry_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [15:0]        pixel_out_o,
  output logic [1:0]         channel_index_o,
  output logic [6:0]         dark_share_o,
  output logic               black_flag_o,
  output logic [6:0]         mean_x_o,
  output logic [14:0]        line_pixel_count_o,
  output logic signed [15:0] line_offset_o,
  output logic               last_o
);

  back_state_e state_q, state_d;

  logic [14:0] cd_q [CHANNELS];
  logic [14:0] cd_d [CHANNELS];
  logic [14:0] ct_q [CHANNELS];
  logic [14:0] ct_d [CHANNELS];
  logic [21:0] cx_q [CHANNELS];
  logic [21:0] cx_d [CHANNELS];
  logic [14:0] ld_q, ld_d;
  logic [21:0] lx_q, lx_d;

  logic [CH_W-1:0] ch_q, ch_d;
  logic [6:0]      pct_q, pct_d;
  logic [6:0]      cen_q, cen_d;
  logic [24:0]     num_q, num_d;
  logic [23:0]     den_q, den_d;
  logic [15:0]     err_q, err_d;

  logic        out_valid_q, out_valid_d;
  logic [1:0]  kind_q, kind_d;
  logic [15:0] pix_q, pix_d;
  logic [1:0]  idx_q, idx_d;
  logic [6:0]  opct_q, opct_d;
  logic        flag_q, flag_d;
  logic [6:0]  ocen_q, ocen_d;
  logic [14:0] cnt_q, cnt_d;
  logic [15:0] oerr_q, oerr_d;
  logic        last_q, last_d;

  logic              out_load, pop, ch_emit, ln_emit, div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  logic            in_rows, in_box, line_hit, summary, flag;
  logic [10:0]     dx4;
  logic [CH_W-1:0] k;
  logic [24:0]     mag;
  logic [15:0]     q16;

  lbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_load = !out_valid_q || !out_stall_i;

  assign in_rows  = geom_i.ok && entry_i.y >= geom_i.y0 && entry_i.y < geom_i.y1;
  assign in_box   = in_rows && 8'(entry_i.x) >= geom_i.x0 && 8'(entry_i.x) < geom_i.x1;
  assign line_hit = in_rows && entry_i.dark &&
                    8'(entry_i.x) >= geom_i.cx0 && 8'(entry_i.x) < geom_i.cx1;
  assign summary  = entry_i.end_frame && geom_i.ok;
  assign dx4      = (11'(entry_i.x) - 11'(geom_i.x0)) << CH_W;

  always_comb begin
    k = '0;
    for (int j = 1; j < CHANNELS; j++) begin
      if (dx4 >= geom_i.bnd[j]) begin
        k = CH_W'(j);
      end
    end
  end

  assign flag = (ct_q[0] != '0) &&
                (22'(cd_q[0]) * 22'd100 >= 22'(ct_q[0]) * 22'(geom_i.adp));
  assign mag  = num_q[24] ? (~num_q + 25'd1) : num_q;
  assign q16  = div_quo[15:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_PIX: begin
        if (!empty_i && out_load && summary) begin
          state_d = BK_PCT_GO;
        end
      end
      BK_PCT_GO:   state_d = BK_PCT_WAIT;
      BK_PCT_WAIT: if (div_done) state_d = BK_CEN_GO;
      BK_CEN_GO:   state_d = BK_CEN_WAIT;
      BK_CEN_WAIT: if (div_done) state_d = BK_CH_OUT;
      BK_CH_OUT: begin
        if (out_load) begin
          state_d = (ch_q == CH_W'(CHANNELS - 1)) ? BK_LN_MUL : BK_PCT_GO;
        end
      end
      BK_LN_MUL:   state_d = BK_LN_GO;
      BK_LN_GO:    state_d = BK_LN_WAIT;
      BK_LN_WAIT:  if (div_done) state_d = BK_LN_OUT;
      BK_LN_OUT:   if (out_load) state_d = BK_PIX;
      default:     state_d = BK_PIX;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    ch_emit   = 1'b0;
    ln_emit   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      BK_PIX:    pop = !empty_i && out_load;
      BK_PCT_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(22'(cd_q[0]) * 22'd100);
        div_den   = DIV_DW'(ct_q[0]);
      end
      BK_CEN_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(cx_q[0]);
        div_den   = DIV_DW'(cd_q[0]);
      end
      BK_CH_OUT: ch_emit = out_load;
      BK_LN_GO: begin
        div_start = 1'b1;
        div_num   = {1'b0, mag, 14'b0};
        div_den   = den_q;
      end
      BK_LN_OUT: ln_emit = out_load;
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      cd_d[c] = cd_q[c];
      ct_d[c] = ct_q[c];
      cx_d[c] = cx_q[c];
    end
    ld_d = ld_q;
    lx_d = lx_q;
    if (pop) begin
      if (entry_i.end_frame && !geom_i.ok) begin
        for (int c = 0; c < CHANNELS; c++) begin
          cd_d[c] = '0;
          ct_d[c] = '0;
          cx_d[c] = '0;
        end
        ld_d = '0;
        lx_d = '0;
      end else begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (in_box && k == CH_W'(c)) begin
            ct_d[c] = ct_q[c] + 15'd1;
            if (entry_i.dark) begin
              cd_d[c] = cd_q[c] + 15'd1;
              cx_d[c] = cx_q[c] + 22'(entry_i.x);
            end
          end
        end
        if (line_hit) begin
          ld_d = ld_q + 15'd1;
          lx_d = lx_q + 22'(entry_i.x);
        end
      end
    end else if (ch_emit) begin
      for (int c = 0; c < CHANNELS - 1; c++) begin
        cd_d[c] = cd_q[c+1];
        ct_d[c] = ct_q[c+1];
        cx_d[c] = cx_q[c+1];
      end
      cd_d[CHANNELS-1] = '0;
      ct_d[CHANNELS-1] = '0;
      cx_d[CHANNELS-1] = '0;
    end else if (ln_emit) begin
      ld_d = '0;
      lx_d = '0;
    end
  end

  always_comb begin
    ch_d  = pop ? '0 : (ch_emit ? ch_q + 1'b1 : ch_q);
    pct_d = pct_q;
    cen_d = cen_q;
    num_d = num_q;
    den_d = den_q;
    err_d = err_q;
    if (state_q == BK_PCT_WAIT && div_done) begin
      pct_d = (ct_q[0] == '0) ? 7'd0 : div_quo[6:0];
    end
    if (state_q == BK_CEN_WAIT && div_done) begin
      cen_d = (cd_q[0] == '0) ? 7'd0 : div_quo[6:0];
    end
    if (state_q == BK_LN_MUL) begin
      num_d = 25'({lx_q, 1'b0}) - 25'(24'(ld_q) * 24'(geom_i.cxsum));
      den_d = 24'(ld_q) * 24'(geom_i.span);
    end
    if (state_q == BK_LN_WAIT && div_done) begin
      if (ld_q == '0 || den_q == '0) begin
        err_d = '0;
      end else begin
        err_d = num_q[24] ? (~q16 + 16'd1) : q16;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    pix_d       = pix_q;
    idx_d       = idx_q;
    opct_d      = opct_q;
    flag_d      = flag_q;
    ocen_d      = ocen_q;
    cnt_d       = cnt_q;
    oerr_d      = oerr_q;
    last_d      = last_q;
    if (pop || ch_emit || ln_emit) begin
      out_valid_d = 1'b1;
      pix_d       = '0;
      idx_d       = '0;
      opct_d      = '0;
      flag_d      = 1'b0;
      ocen_d      = '0;
      cnt_d       = '0;
      oerr_d      = '0;
      last_d      = 1'b0;
      if (pop) begin
        kind_d = KIND_PIXEL;
        if (geom_i.ok) begin
          pix_d = entry_i.dark ? PIX_DARK : PIX_LIGHT;
        end else begin
          pix_d = entry_i.word;
        end
        last_d = !summary;
      end else if (ch_emit) begin
        kind_d = KIND_CHANNEL;
        idx_d  = 2'(ch_q);
        opct_d = pct_q;
        flag_d = flag;
        ocen_d = cen_q;
      end else begin
        kind_d = KIND_LINE;
        cnt_d  = ld_q;
        oerr_d = err_q;
        last_d = 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_PIX;
      out_valid_q <= 1'b0;
      ch_q        <= '0;
      ld_q        <= '0;
      lx_q        <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        cd_q[c] <= '0;
        ct_q[c] <= '0;
        cx_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ch_q        <= ch_d;
      ld_q        <= ld_d;
      lx_q        <= lx_d;
      for (int c = 0; c < CHANNELS; c++) begin
        cd_q[c] <= cd_d[c];
        ct_q[c] <= ct_d[c];
        cx_q[c] <= cx_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pct_q  <= pct_d;
    cen_q  <= cen_d;
    num_q  <= num_d;
    den_q  <= den_d;
    err_q  <= err_d;
    kind_q <= kind_d;
    pix_q  <= pix_d;
    idx_q  <= idx_d;
    opct_q <= opct_d;
    flag_q <= flag_d;
    ocen_q <= ocen_d;
    cnt_q  <= cnt_d;
    oerr_q <= oerr_d;
    last_q <= last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign pixel_out_o        = pix_q;
  assign channel_index_o    = idx_q;
  assign dark_share_o       = opct_q;
  assign black_flag_o       = flag_q;
  assign mean_x_o           = ocen_q;
  assign line_pixel_count_o = cnt_q;
  assign line_offset_o      = $signed(oerr_q);
  assign last_o             = last_q;

endmodule

[rtl/line_roi_threshold_centroid.sv]
// Pixel thresholding with ROI channel statistics and a line centroid.
// Input channel: in_valid_i / in_stall_o carry one byte-swapped RGB565
// pixel per transfer, in raster order; the block keeps its own x/y.
// Output channel: out_valid_o / out_stall_i carry one result per transfer:
// a pixel per input, binarized, or raw when the ROI geometry is invalid;
// with valid geometry a frame's last pixel is followed by four channel
// results and one line summary; last_o marks each pixel's final result.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i.
// A pixel result is registered after the queue; one pixel per cycle is
// sustained while the output is not stalled and no frame-end work runs.
// At the end of a frame with valid ROI geometry the result stage runs nine
// divisions on a shared bit-serial divider, while the four-entry queue fills
// and then stalls the input. After reset and after each configuration
// write the input stalls while the ROI geometry pipeline settles. A stalled
// output holds its result; the queue keeps taking pixels until it is full.
module line_roi_threshold_centroid import lbc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        pixel_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         result_kind_o,
  output logic [15:0]        pixel_out_o,
  output logic [1:0]         channel_index_o,
  output logic [6:0]         dark_share_o,
  output logic               black_flag_o,
  output logic [6:0]         mean_x_o,
  output logic [14:0]        line_pixel_count_o,
  output logic signed [15:0] line_offset_o,
  output logic               last_o
);

  geom_t      geom;
  pix_entry_t push_entry, pop_entry;
  logic       push, pop, full, empty;

  lbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_word_i (pixel_word_i),
    .fifo_full_i  (full),
    .push_o       (push),
    .entry_o      (push_entry),
    .geom_o       (geom)
  );

  lbc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .full_o      (full),
    .empty_o     (empty)
  );

  lbc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .geom_i             (geom),
    .entry_i            (pop_entry),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .pixel_out_o        (pixel_out_o),
    .channel_index_o    (channel_index_o),
    .dark_share_o       (dark_share_o),
    .black_flag_o       (black_flag_o),
    .mean_x_o           (mean_x_o),
    .line_pixel_count_o (line_pixel_count_o),
    .line_offset_o      (line_offset_o),
    .last_o             (last_o)
  );

endmodule

[sim/tb_top.sv]
module tb_top;
  import lbc_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pix;
    logic [1:0]  chan;
    logic [6:0]  pct;
    logic        flag;
    logic [6:0]  cen;
    logic [14:0] lcount;
    logic [15:0] lerr;
    logic        last;
  } line_result_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    reg_idx;
    logic [7:0]  value;
    logic [15:0] word;
    bit          typed;
    logic [15:0] pix;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_index_i;
  logic [7:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [15:0]       pixel_word_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        result_kind_o;
  logic [15:0]       pixel_out_o;
  logic [1:0]        channel_index_o;
  logic [6:0]        dark_share_o;
  logic              black_flag_o;
  logic [6:0]        mean_x_o;
  logic [14:0]       line_pixel_count_o;
  logic signed [15:0] line_offset_o;
  logic              last_o;

  line_roi_threshold_centroid dut (.*);

  // predictor state
  int unsigned frame_w, frame_h, dark_thr, top_pct, bot_pct, width_pct, active_pct;
  int          offset_pct;
  int unsigned col_pos, row_pos;
  int unsigned ch_dark [CHANNELS];
  int unsigned ch_total [CHANNELS];
  int unsigned ch_xsum [CHANNELS];
  int unsigned ln_dark, ln_xsum;

  line_result_t pending_results[$];
  bit           failed;
  bit           calm;
  bit           hold_req;
  int unsigned  idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic apply_cfg(cfg_reg_e idx, logic [7:0] v);
    case (idx)
      CFG_FRAME_WIDTH:  frame_w = 32'(v);
      CFG_FRAME_HEIGHT: frame_h = 32'(v);
      CFG_DARK_THR:     dark_thr = 32'(v);
      CFG_ROI_TOP:      top_pct = 32'(v[6:0]);
      CFG_ROI_BOTTOM:   bot_pct = 32'(v[6:0]);
      CFG_ROI_WIDTH:    width_pct = 32'(v[6:0]);
      CFG_ROI_OFFSET:   offset_pct = int'($signed(v[6:0]));
      CFG_ACTIVE_DARK:  active_pct = 32'(v[6:0]);
      default: ;
    endcase
  endtask

  task automatic clear_sums();
    for (int c = 0; c < CHANNELS; c++) begin
      ch_dark[c] = 0;
      ch_total[c] = 0;
      ch_xsum[c] = 0;
    end
    ln_dark = 0;
    ln_xsum = 0;
  endtask

  task automatic predict_pixel(logic [15:0] word, bit typed, logic [15:0] typed_pix);
    int unsigned w, h, y0, y1, rw, wp, x0, x1, ex, cx0, cx1, cw, chh, lum, k;
    int unsigned rr, gg, bb, x, y;
    int          xs;
    bit          ok, dark, end_row, end_frame;
    logic [15:0] rgb;
    longint      num, den, err;
    line_result_t res;
    wp  = width_pct > 100 ? 100 : width_pct;
    w   = frame_w > MAX_WIDTH ? MAX_WIDTH : frame_w;
    h   = frame_h > MAX_HEIGHT ? MAX_HEIGHT : frame_h;
    y0  = h * top_pct / 100;
    y1  = h * bot_pct / 100;
    rw  = w * wp / 100;
    ok  = !(w < CHANNELS || h == 0 || y1 <= y0 || rw == 0);
    xs  = (int'(w) - int'(rw)) / 2 + int'(w) * offset_pct / 100;
    if (xs < 0) xs = 0;
    if (xs + int'(rw) > int'(w)) xs = int'(w) - int'(rw);
    x0  = xs;
    x1  = x0 + rw;
    ex  = rw * 20 / 100;
    cx0 = x0 + ex;
    cx1 = x1 - ex;
    rgb = {word[7:0], word[15:8]};
    rr  = 32'(rgb[15:11]);
    gg  = 32'(rgb[10:5]);
    bb  = 32'(rgb[4:0]);
    lum = (77 * rr * 255 / 31 + 150 * gg * 255 / 63 + 29 * bb * 255 / 31) >> 8;
    dark = lum <= dark_thr;
    x = col_pos;
    y = row_pos;
    cw  = w == 0 ? 1 : w;
    chh = h == 0 ? 1 : h;
    end_row   = x + 1 >= cw;
    end_frame = end_row && (y + 1 >= chh);

    res = '0;
    res.kind = KIND_PIXEL;
    res.pix  = ok ? (dark ? PIX_DARK : PIX_LIGHT) : word;
    if (typed) res.pix = typed_pix;
    res.last = !(end_frame && ok);
    pending_results.push_back(res);

    if (ok && y >= y0 && y < y1) begin
      if (x >= x0 && x < x1) begin
        k = (x - x0) * CHANNELS / rw;
        if (k >= CHANNELS) k = CHANNELS - 1;
        ch_total[k]++;
        if (dark) begin
          ch_dark[k]++;
          ch_xsum[k] += x;
        end
      end
      if (dark && x >= cx0 && x < cx1) begin
        ln_dark++;
        ln_xsum += x;
      end
    end

    if (end_frame && ok) begin
      for (int c = 0; c < CHANNELS; c++) begin
        res = '0;
        res.kind = KIND_CHANNEL;
        res.chan = 2'(c);
        res.pct  = ch_total[c] != 0 ? 7'(ch_dark[c] * 100 / ch_total[c]) : '0;
        res.flag = ch_total[c] != 0 && ch_dark[c] * 100 >= ch_total[c] * active_pct;
        res.cen  = ch_dark[c] != 0 ? 7'(ch_xsum[c] / ch_dark[c]) : '0;
        pending_results.push_back(res);
      end
      err = 0;
      if (ln_dark != 0) begin
        num = 2 * longint'(ln_xsum) - longint'(ln_dark) * longint'(cx0 + cx1);
        den = longint'(ln_dark) * longint'(cx1 - cx0);
        if (den != 0) err = num * 16384 / den;
      end
      res = '0;
      res.kind   = KIND_LINE;
      res.lcount = 15'(ln_dark);
      res.lerr   = 16'(err);
      res.last   = 1'b1;
      pending_results.push_back(res);
    end

    if (end_row) begin
      col_pos = 0;
      row_pos = end_frame ? 0 : ((y + 1) & 8'hFF);
    end else begin
      col_pos = (x + 1) & 7'h7F;
    end
    if (end_frame) clear_sums();
  endtask

  // caller stands at a falling edge with the input channel idle
  task automatic write_cfg(cfg_reg_e idx, logic [7:0] v);
    wait (pending_results.size() == 0);
    @(negedge clk_i);
    repeat (12) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    apply_cfg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [15:0] word, bit typed, logic [15:0] typed_pix);
    while (!calm && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pixel(word, typed, typed_pix);
    @(negedge clk_i);
  endtask

  task automatic pause_input();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // compare accepted results
  always @(posedge clk_i) begin
    line_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer, kind %0d", result_kind_o);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        check_field("result_kind", e.kind, result_kind_o);
        check_field("pixel_out", e.pix, pixel_out_o);
        check_field("channel_index", e.chan, channel_index_o);
        check_field("dark_share", e.pct, dark_share_o);
        check_field("black_flag", e.flag, black_flag_o);
        check_field("mean_x", e.cen, mean_x_o);
        check_field("line_pixel_count", e.lcount, line_pixel_count_o);
        check_field("line_offset", $signed(e.lerr), line_offset_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  // receiver stalls
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= !calm && $urandom_range(99) < 33;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 6000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  stim_row_t   directed[$];
  int unsigned sent, frames, n_pix, w_eff, h_eff, phase;

  function automatic stim_row_t px(logic [15:0] word, bit typed, logic [15:0] pix);
    stim_row_t r;
    r = '{is_cfg: 1'b0, reg_idx: CFG_FRAME_WIDTH, value: '0, word: word,
          typed: typed, pix: pix};
    return r;
  endfunction

  function automatic stim_row_t cf(cfg_reg_e idx, logic [7:0] v);
    stim_row_t r;
    r = '{is_cfg: 1'b1, reg_idx: idx, value: v, word: '0, typed: 1'b0, pix: '0};
    return r;
  endfunction

  initial begin
    failed = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_FRAME_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pixel_word_i = '0;
    frame_w = 128; frame_h = 160; dark_thr = 110; top_pct = 0; bot_pct = 8;
    width_pct = 30; offset_pct = -7; active_pct = 20;
    col_pos = 0; row_pos = 0;
    clear_sums();

    directed = '{
      px(16'h0000, 1, PIX_DARK), px(16'hFFFF, 1, PIX_LIGHT),
      px(16'h00F8, 0, '0), px(16'hE007, 0, '0), px(16'h1F00, 0, '0),
      cf(CFG_DARK_THR, 8'd255), px(16'hFFFF, 1, PIX_DARK),
      cf(CFG_DARK_THR, 8'd0), px(16'h0000, 1, PIX_DARK), px(16'h2000, 1, PIX_LIGHT),
      cf(CFG_FRAME_WIDTH, 8'd4), cf(CFG_FRAME_HEIGHT, 8'd1), cf(CFG_ROI_TOP, 8'd0),
      cf(CFG_ROI_BOTTOM, 8'd100), cf(CFG_ROI_WIDTH, 8'd100), cf(CFG_ROI_OFFSET, 8'd0),
      cf(CFG_ACTIVE_DARK, 8'd0), cf(CFG_DARK_THR, 8'd110),
      px(16'h0000, 0, '0), px(16'hFFFF, 0, '0), px(16'h0000, 0, '0), px(16'h0000, 0, '0),
      cf(CFG_FRAME_WIDTH, 8'd3), px(16'h1234, 1, 16'h1234), px(16'hABCD, 1, 16'hABCD)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        pause_input();
        write_cfg(directed[i].reg_idx, directed[i].value);
      end else begin
        send_pixel(directed[i].word, directed[i].typed, directed[i].pix);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < 480) begin
      pause_input();
      calm = (phase == 1);
      if (phase % 9 == 3) begin
        write_cfg(CFG_FRAME_WIDTH, 8'd255);
        write_cfg(CFG_FRAME_HEIGHT, 8'd1);
      end else if (phase == 6) begin
        write_cfg(CFG_FRAME_WIDTH, 8'd4);
        write_cfg(CFG_FRAME_HEIGHT, 8'd160);
      end else if (phase == 10) begin
        write_cfg(CFG_FRAME_WIDTH, 8'd128);
        write_cfg(CFG_FRAME_HEIGHT, 8'd255);
        write_cfg(CFG_ROI_TOP, 8'd99);
        write_cfg(CFG_ROI_BOTTOM, 8'd100);
      end else begin
        write_cfg(CFG_FRAME_WIDTH, 8'($urandom_range(99) < 10 ? $urandom_range(3)
                                                              : $urandom_range(12, 4)));
        write_cfg(CFG_FRAME_HEIGHT, 8'($urandom_range(99) < 5 ? 0 : $urandom_range(4, 1)));
      end
      if (phase != 10) begin
        write_cfg(CFG_ROI_TOP, 8'($urandom_range(99) < 40 ? 0 : $urandom_range(127)));
        write_cfg(CFG_ROI_BOTTOM, 8'($urandom_range(99) < 40 ? 100 : $urandom_range(255)));
      end
      write_cfg(CFG_DARK_THR, 8'($urandom_range(255)));
      write_cfg(CFG_ROI_WIDTH, 8'($urandom_range(99) < 30 ? 100 : $urandom_range(255)));
      write_cfg(CFG_ROI_OFFSET, $urandom_range(99) < 20 ? 8'(-50) : 8'($urandom_range(255)));
      write_cfg(CFG_ACTIVE_DARK, 8'($urandom_range(99) < 20 ? 100 : $urandom_range(255)));
      if (phase == 3) hold_req = 1'b1;
      w_eff = frame_w > MAX_WIDTH ? MAX_WIDTH : (frame_w == 0 ? 1 : frame_w);
      h_eff = frame_h > MAX_HEIGHT ? MAX_HEIGHT : (frame_h == 0 ? 1 : frame_h);
      frames = (w_eff * h_eff > 100) ? 1 : $urandom_range(3, 1);
      n_pix = frames * w_eff * h_eff + $urandom_range(3) -
              ((col_pos + row_pos * w_eff) % (w_eff * h_eff));
      if (phase == 10) n_pix = 2 * w_eff;
      if (n_pix > 480 - sent) n_pix = 480 - sent;
      for (int i = 0; i < int'(n_pix); i++) begin
        send_pixel($urandom_range(99) < 30 ? 16'($urandom_range(99) < 50 ? 0 : 16'hFFFF)
                                           : 16'($urandom), 1'b0, '0);
      end
      sent += n_pix;
      phase++;
    end
    calm = 1'b0;
    pause_input();

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
